// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons in the same cycle
`define CHK_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// expr never holds
`define CHK_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// File: rtl/csem_pkg.sv
// ----------------------------------------------------------------------------
// csem_pkg
// Constants and codes for the counting semaphore with FIFO wait queue.
// ----------------------------------------------------------------------------
package csem_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int COUNT_BITS_DEF  = 16;
	localparam int ID_BITS_DEF     = 6;

	// port field widths
	localparam int OP_W     = 2;
	localparam int REQ_W    = 6;
	localparam int STATUS_W = 3;
	localparam int CFG_W    = 16;
	localparam int CNT_O_W  = 16;
	localparam int WAIT_O_W = 5;

	// op codes
	localparam logic [OP_W-1:0] OP_DOWN   = 2'd0;
	localparam logic [OP_W-1:0] OP_UP     = 2'd1;
	localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STS_GRANTED     = 3'd0;
	localparam logic [STATUS_W-1:0] STS_QUEUED      = 3'd1;
	localparam logic [STATUS_W-1:0] STS_RAISED      = 3'd2;
	localparam logic [STATUS_W-1:0] STS_WOKEN       = 3'd3;
	localparam logic [STATUS_W-1:0] STS_TIMEDOUT    = 3'd4;
	localparam logic [STATUS_W-1:0] STS_INTERRUPTED = 3'd5;
	localparam logic [STATUS_W-1:0] STS_NOTFOUND    = 3'd6;
	localparam logic [STATUS_W-1:0] STS_FULL        = 3'd7;

endpackage

// File: rtl/csem_ram.sv
// ----------------------------------------------------------------------------
// csem_ram
// Wait queue storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module csem_ram #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 6,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/csem_ctrl.sv
// ----------------------------------------------------------------------------
// csem_ctrl
// Sequencer: count register, circular queue pointers, cancel scan with
// in-place compaction, and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csem_ctrl
	import csem_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF,
	parameter int ID_BITS     = ID_BITS_DEF,
	parameter int PTR_W       = 4,
	parameter int LEN_W       = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_W-1:0]      cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [OP_W-1:0]       in_op,
	input  logic [ID_BITS-1:0]    in_id,
	input  logic                  in_intr,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STATUS_W-1:0]   out_status,
	output logic [ID_BITS-1:0]    out_woken,
	output logic [COUNT_BITS-1:0] out_count,
	output logic [LEN_W-1:0]      out_len,
	output logic                  ram_wr_en,
	output logic [PTR_W-1:0]      ram_wr_addr,
	output logic [ID_BITS-1:0]    ram_wr_data,
	output logic                  ram_rd_en,
	output logic [PTR_W-1:0]      ram_rd_addr,
	input  logic [ID_BITS-1:0]    ram_rd_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_UPRD,
		S_SCAN,
		S_RESP
	} state_t;

	localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(QUEUE_DEPTH);

	state_t                state_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [LEN_W-1:0]      len_q;
	logic [PTR_W-1:0]      head_q;
	logic [PTR_W-1:0]      curp_q;
	logic [PTR_W-1:0]      prevp_q;
	logic [LEN_W-1:0]      idx_q;
	logic                  found_q;
	logic [ID_BITS-1:0]    id_q;
	logic                  intr_q;
	logic [STATUS_W-1:0]   status_q;
	logic [ID_BITS-1:0]    woken_q;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [ID_BITS-1:0]    out_woken_q;
	logic [COUNT_BITS-1:0] out_count_q;
	logic [LEN_W-1:0]      out_len_q;

	logic                  accept;
	logic                  hit;
	logic                  scan_last;
	logic                  down_queue;
	logic [PTR_W:0]        tail_sum;
	logic [PTR_W-1:0]      tail;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W:0] n;
		n = {1'b0, p} + (PTR_W+1)'(1);
		if (n >= (PTR_W+1)'(QUEUE_DEPTH)) begin
			n = '0;
		end
		return n[PTR_W-1:0];
	endfunction

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign hit        = (ram_rd_data == id_q);
	assign scan_last  = (idx_q == len_q - LEN_W'(1));
	assign down_queue = accept && (in_op == OP_DOWN) && (count_q == '0) && (len_q != LEN_FULL);

	always_comb begin
		tail_sum = {1'b0, head_q} + (PTR_W+1)'(len_q);
		if (tail_sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
			tail_sum = tail_sum - (PTR_W+1)'(QUEUE_DEPTH);
		end
		tail = tail_sum[PTR_W-1:0];
	end

	assign ram_wr_en   = down_queue || ((state_q == S_SCAN) && found_q);
	assign ram_wr_addr = (state_q == S_SCAN) ? prevp_q : tail;
	assign ram_wr_data = (state_q == S_SCAN) ? ram_rd_data : in_id;
	assign ram_rd_en   = (accept && (len_q != '0) && ((in_op == OP_UP) || (in_op == OP_CANCEL)))
		|| ((state_q == S_SCAN) && !scan_last);
	assign ram_rd_addr = (state_q == S_SCAN) ? ptr_next(curp_q) : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= COUNT_BITS'(1);
			len_q        <= '0;
			head_q       <= '0;
			curp_q       <= '0;
			prevp_q      <= '0;
			idx_q        <= '0;
			found_q      <= 1'b0;
			id_q         <= '0;
			intr_q       <= 1'b0;
			status_q     <= STS_NOTFOUND;
			woken_q      <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= STS_NOTFOUND;
			out_woken_q  <= '0;
			out_count_q  <= '0;
			out_len_q    <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				count_q <= COUNT_BITS'(cfg_wr_data);
				len_q   <= '0;
				head_q  <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						id_q     <= in_id;
						intr_q   <= in_intr;
						woken_q  <= '0;
						status_q <= STS_NOTFOUND;
						state_q  <= S_RESP;
						unique case (in_op)
							OP_DOWN: begin
								if (count_q != '0) begin
									count_q  <= count_q - COUNT_BITS'(1);
									status_q <= STS_GRANTED;
								end else if (len_q == LEN_FULL) begin
									status_q <= STS_FULL;
								end else begin
									len_q    <= len_q + LEN_W'(1);
									status_q <= STS_QUEUED;
								end
							end
							OP_UP: begin
								if (len_q != '0) begin
									state_q <= S_UPRD;
								end else if (&count_q) begin
									status_q <= STS_FULL;
								end else begin
									count_q  <= count_q + COUNT_BITS'(1);
									status_q <= STS_RAISED;
								end
							end
							OP_CANCEL: begin
								if (len_q != '0) begin
									state_q <= S_SCAN;
									idx_q   <= '0;
									found_q <= 1'b0;
									curp_q  <= head_q;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_UPRD: begin
					woken_q  <= ram_rd_data;
					head_q   <= ptr_next(head_q);
					len_q    <= len_q - LEN_W'(1);
					status_q <= STS_WOKEN;
					state_q  <= S_RESP;
				end
				S_SCAN: begin
					if (!found_q && hit) begin
						found_q <= 1'b1;
					end
					prevp_q <= curp_q;
					curp_q  <= ptr_next(curp_q);
					idx_q   <= idx_q + LEN_W'(1);
					if (scan_last) begin
						state_q <= S_RESP;
						if (found_q || hit) begin
							len_q    <= len_q - LEN_W'(1);
							status_q <= intr_q ? STS_INTERRUPTED : STS_TIMEDOUT;
						end
					end
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_woken_q  <= woken_q;
						out_count_q  <= count_q;
						out_len_q    <= len_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_woken  = out_woken_q;
	assign out_count  = out_count_q;
	assign out_len    = out_len_q;

	`CHK_NEVER(a_len_bound, len_q > LEN_FULL, "queue length above depth")
	`CHK_IMPL(a_wr_ctx, ram_wr_en, (state_q == S_IDLE) || (state_q == S_SCAN && found_q), "stray write")
	`CHK_IMPL(a_scan_idx, state_q == S_SCAN, idx_q < len_q, "scan ran past tail")
	`CHK_IMPL(a_uprd_len, state_q == S_UPRD, len_q != '0, "wake with empty queue")

endmodule

// File: rtl/counting_semaphore_fifo_waiters.sv
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters
// Counting semaphore with a FIFO queue of waiting requester ids.
//
//   channel  | dir | tdata fields (low bit up)                 | tuser
//   s_axis   | in  | requester[5:0], cancel_interrupted[6]     | op[1:0]
//   m_axis   | out | woken_id[5:0], count_now[21:6],           | status[2:0]
//            |     | waiters_now[26:22]                        |
//   cfg      | in  | cfg_wr_data = initial_count, cfg_wr_en    |
//
// From input transfer to result in the output register: down, up on an
// empty queue, unused op and cancel on an empty queue go straight to the
// response state; up with waiters first reads the queue RAM head; cancel
// scans all the waiters, one RAM entry per cycle, before the response state.
// A result waits until the previous one has left; the input stays blocked.
// Reset: count = 1, queue empty; no RAM clearing pass. A config write
// reloads the count and empties the queue.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters
	import csem_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF,
	parameter int ID_BITS     = ID_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // requester[5:0], cancel_interrupted[6]
	input  logic [1:0]  s_axis_tuser,   // op[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // woken_id[5:0], count_now[21:6], waiters_now[26:22]
	output logic [2:0]  m_axis_tuser    // status[2:0]
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LEN_W = $clog2(QUEUE_DEPTH + 1) > 0 ? $clog2(QUEUE_DEPTH + 1) : 1;

	logic                  ram_wr_en;
	logic [PTR_W-1:0]      ram_wr_addr;
	logic [ID_BITS-1:0]    ram_wr_data;
	logic                  ram_rd_en;
	logic [PTR_W-1:0]      ram_rd_addr;
	logic [ID_BITS-1:0]    ram_rd_data;
	logic [ID_BITS-1:0]    in_id;
	logic [ID_BITS-1:0]    out_woken;
	logic [COUNT_BITS-1:0] out_count;
	logic [LEN_W-1:0]      out_len;
	logic [STATUS_W-1:0]   out_status;

	assign in_id = ID_BITS'(s_axis_tdata[REQ_W-1:0]);

	csem_ram #(
		.DEPTH  (QUEUE_DEPTH),
		.WIDTH  (ID_BITS),
		.ADDR_W (PTR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	csem_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.COUNT_BITS  (COUNT_BITS),
		.ID_BITS     (ID_BITS),
		.PTR_W       (PTR_W),
		.LEN_W       (LEN_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_op       (s_axis_tuser),
		.in_id       (in_id),
		.in_intr     (s_axis_tdata[REQ_W]),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_status  (out_status),
		.out_woken   (out_woken),
		.out_count   (out_count),
		.out_len     (out_len),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data)
	);

	assign m_axis_tuser = out_status;
	assign m_axis_tdata = {5'b0, WAIT_O_W'(out_len), CNT_O_W'(out_count), REQ_W'(out_woken)};

endmodule

// File: sim/counting_semaphore_fifo_waiters_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters_test
// Drives down, up and cancel requests through the stream input with bursty
// pacing. Reply-side backpressure follows a rotating stall pattern. A tracker
// keeps its own count and waiter queue, predicts every reply and compares
// each field of the replies in order. Runs several initial counts, including
// zero and the saturation limit.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters_test;
	import csem_pkg::*;

	localparam logic [OP_W-1:0] OP_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 24;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [5:0]          woken_id;
		logic [15:0]         count_now;
		logic [4:0]          waiters_now;
	} sem_reply_t;

	class semaphore_tracker;
		logic [15:0] units;
		logic [5:0]  waiters[$];
		sem_reply_t  replies_due[$];
		int          errors;

		function new();
			units = 16'd1;
			errors = 0;
		endfunction

		function void reinit(logic [15:0] init_units);
			units = init_units;
			waiters.delete();
		endfunction

		function int pending();
			return replies_due.size();
		endfunction

		function void note_request(logic [1:0] op, logic [5:0] id, logic intr);
			sem_reply_t r;
			bit found;
			r = '0;
			r.status = STS_NOTFOUND;
			found = 0;
			case (op)
				OP_DOWN: begin
					if (units != 0) begin
						units--;
						r.status = STS_GRANTED;
					end else if (waiters.size() >= QUEUE_DEPTH_DEF) begin
						r.status = STS_FULL;
					end else begin
						waiters.push_back(id);
						r.status = STS_QUEUED;
					end
				end
				OP_UP: begin
					if (waiters.size() == 0) begin
						if (units == 16'hFFFF) begin
							r.status = STS_FULL;
						end else begin
							units++;
							r.status = STS_RAISED;
						end
					end else begin
						r.woken_id = waiters.pop_front();
						r.status = STS_WOKEN;
					end
				end
				OP_CANCEL: begin
					for (int i = 0; i < waiters.size() && !found; i++) begin
						if (waiters[i] == id) begin
							waiters.delete(i);
							found = 1;
						end
					end
					if (found)
						r.status = intr ? STS_INTERRUPTED : STS_TIMEDOUT;
				end
				default: ;
			endcase
			r.count_now = units;
			r.waiters_now = 5'(waiters.size());
			replies_due.push_back(r);
		endfunction

		function void report(string field, int expv, int actv);
			if (expv != actv) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, expv, actv);
			end
		endfunction

		function void check_reply(sem_reply_t got);
			sem_reply_t want;
			if (replies_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected reply, expected none actual status %0d",
					$time, got.status);
				return;
			end
			want = replies_due.pop_front();
			report("status", int'(want.status), int'(got.status));
			report("woken_id", int'(want.woken_id), int'(got.woken_id));
			report("count_now", int'(want.count_now), int'(got.count_now));
			report("waiters_now", int'(want.waiters_now), int'(got.waiters_now));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // requester[5:0], cancel_interrupted[6]
	logic [1:0]  s_axis_tuser = '0;   // op[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [31:0] m_axis_tdata;        // woken_id[5:0], count_now[21:6], waiters_now[26:22]
	logic [2:0]  m_axis_tuser;        // status[2:0]

	semaphore_tracker sem;
	int          cycles = 0;
	int          burst_left = 0;
	logic [12:0] stall_pat = 13'h1FFF;
	int          pat_age = 0;

	counting_semaphore_fifo_waiters u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** counting_semaphore_fifo_waiters: FAILED **");
			$finish;
		end
	end

	// reply side: check transfers, stall on a rotating pattern
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sem.check_reply({m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[21:6],
				m_axis_tdata[26:22]});
		if (pat_age == 0) begin
			stall_pat <= ($urandom_range(0, 2) == 0) ? 13'h1FFF : (13'($urandom) | 13'h1);
			pat_age <= $urandom_range(50, 400);
		end else begin
			stall_pat <= {stall_pat[11:0], stall_pat[12]};
			pat_age <= pat_age - 1;
		end
		m_axis_tready <= stall_pat[12];
	end

	task automatic issue_request(input logic [1:0] op, input logic [5:0] id, input logic intr);
		s_axis_tdata <= {1'b0, intr, id};
		s_axis_tuser <= op;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sem.note_request(op, id, intr);
	endtask

	task automatic pace_sender();
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 20);
		end
		burst_left--;
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sem.pending() != 0) @(posedge clk);
	endtask

	task automatic set_initial_count(input logic [15:0] init_units);
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_data <= init_units;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sem.reinit(init_units);
		@(posedge clk);
	endtask

	task automatic pick_request(input int down_pct, output logic [1:0] op,
			output logic [5:0] id, output logic intr);
		int r;
		r = $urandom_range(0, 99);
		intr = 1'($urandom_range(0, 1));
		id = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
		if (r < down_pct)
			op = OP_DOWN;
		else if (r < down_pct + (95 - down_pct) * 2 / 3)
			op = OP_UP;
		else if (r < 95)
			op = OP_CANCEL;
		else
			op = OP_NONE;
		if (op == OP_CANCEL && sem.waiters.size() != 0 && $urandom_range(0, 2) != 0)
			id = sem.waiters[$urandom_range(0, sem.waiters.size() - 1)];
	endtask

	task automatic run_phase(input logic [15:0] init_units, input int down_pct, input int n);
		logic [1:0] op;
		logic [5:0] id;
		logic       intr;
		set_initial_count(init_units);
		for (int i = 0; i < n; i++) begin
			if (i == n / 2 || $urandom_range(0, 99) == 0)
				wait_drain();
			pace_sender();
			pick_request(down_pct, op, id, intr);
			issue_request(op, id, intr);
		end
	endtask

	initial begin
		sem = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset count is one: grant, then fill the queue to its depth
		issue_request(OP_DOWN, 6'd0, 1'b0);
		issue_request(OP_DOWN, 6'd63, 1'b1);
		issue_request(OP_DOWN, 6'd63, 1'b0);
		for (int i = 1; i <= 14; i++)
			issue_request(OP_DOWN, 6'(i), 1'b0);
		issue_request(OP_DOWN, 6'd42, 1'b1);      // refused, queue full
		issue_request(OP_CANCEL, 6'd63, 1'b1);    // oldest duplicate, interrupted
		issue_request(OP_CANCEL, 6'd50, 1'b0);    // absent id
		issue_request(OP_CANCEL, 6'd63, 1'b0);    // second copy, timed out
		issue_request(OP_NONE, 6'd21, 1'b1);
		issue_request(OP_UP, 6'd0, 1'b0);         // wakes oldest

		// saturation at the top of the count range
		set_initial_count(16'hFFFF);
		issue_request(OP_UP, 6'd33, 1'b1);
		issue_request(OP_DOWN, 6'd33, 1'b0);
		issue_request(OP_UP, 6'd33, 1'b0);

		run_phase(16'd0, 50, 280);
		run_phase(16'd3, 45, 280);
		run_phase(16'hFFFF, 30, 220);
		run_phase(16'hFFFE, 40, 220);
		run_phase(16'($urandom_range(0, 5)), 60, 320);
		run_phase(16'($urandom), 45, 230);

		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sem.errors == 0 && sem.pending() == 0)
			$display("** counting_semaphore_fifo_waiters: PASSED **");
		else
			$display("** counting_semaphore_fifo_waiters: FAILED **");
		$finish;
	end

endmodule
